FILE: rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, constants and the control program of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int WORDS_PER_BUFFER = 64;
	localparam int WORD_BITS        = 16;
	localparam int VAL_W            = 64;
	localparam int CNT_W            = 7;
	localparam int POS_W            = 5;
	localparam int RADDR_W          = 6;
	localparam int OUT_ADDR_W       = 7;
	localparam int MAX_COUNT        = 64;

	// write address counts up to WORDS_PER_BUFFER itself (buffer full)
	localparam int ADDR_W    = $clog2(WORDS_PER_BUFFER + 1);
	localparam int IDX_W     = (WORDS_PER_BUFFER > 1) ? $clog2(WORDS_PER_BUFFER) : 1;
	localparam int MEM_AW    = IDX_W + 1;
	localparam int MEM_DEPTH = 2 ** MEM_AW;

	localparam logic [POS_W-1:0] POS_FULL = POS_W'(WORD_BITS);

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_MERGE  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic BUF_DATA  = 1'b0;
	localparam logic BUF_SETUP = 1'b1;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHUNK,
		OP_EMIT,
		OP_RD_SEL,
		OP_LD_RWORD,
		OP_RD_DATA,
		OP_LD_WORD
	} op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_GOTO,
		J_DISPATCH,
		J_IF_REM,
		J_IF_WORD,
		J_WAIT_OUT
	} jmp_t;

	localparam int PC_W = 4;

	localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] PC_APPEND   = 4'd1;
	localparam logic [PC_W-1:0] PC_OUT      = 4'd2;
	localparam logic [PC_W-1:0] PC_READ     = 4'd3;
	localparam logic [PC_W-1:0] PC_READ_LD  = 4'd4;
	localparam logic [PC_W-1:0] PC_MERGE    = 4'd5;
	localparam logic [PC_W-1:0] PC_MERGE_LD = 4'd6;
	localparam logic [PC_W-1:0] PC_MERGE_CH = 4'd7;
	localparam logic [PC_W-1:0] PC_MERGE_NX = 4'd8;
	localparam logic [PC_W-1:0] PC_MERGE_DN = 4'd9;

	typedef struct packed {
		op_t             op;
		logic            in_ready;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic       accept;
		logic [1:0] mode;
		logic       rem_more;
		logic       word_more;
		logic       out_busy;
	} status_t;

	// control store
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = '{op: OP_NOP, in_ready: 1'b0, jmp: J_GOTO, target: PC_IDLE};
		case (pc)
			PC_IDLE:     c = '{op: OP_LOAD,     in_ready: 1'b1, jmp: J_DISPATCH, target: PC_IDLE};
			PC_APPEND:   c = '{op: OP_CHUNK,    in_ready: 1'b0, jmp: J_IF_REM,   target: PC_APPEND};
			PC_OUT:      c = '{op: OP_EMIT,     in_ready: 1'b0, jmp: J_WAIT_OUT, target: PC_IDLE};
			PC_READ:     c = '{op: OP_RD_SEL,   in_ready: 1'b0, jmp: J_NEXT,     target: PC_IDLE};
			PC_READ_LD:  c = '{op: OP_LD_RWORD, in_ready: 1'b0, jmp: J_GOTO,     target: PC_OUT};
			PC_MERGE:    c = '{op: OP_RD_DATA,  in_ready: 1'b0, jmp: J_NEXT,     target: PC_IDLE};
			PC_MERGE_LD: c = '{op: OP_LD_WORD,  in_ready: 1'b0, jmp: J_NEXT,     target: PC_IDLE};
			PC_MERGE_CH: c = '{op: OP_CHUNK,    in_ready: 1'b0, jmp: J_IF_REM,   target: PC_MERGE_CH};
			PC_MERGE_NX: c = '{op: OP_NOP,      in_ready: 1'b0, jmp: J_IF_WORD,  target: PC_MERGE};
			PC_MERGE_DN: c = '{op: OP_NOP,      in_ready: 1'b0, jmp: J_GOTO,     target: PC_OUT};
			default:     c = '{op: OP_NOP,      in_ready: 1'b0, jmp: J_GOTO,     target: PC_IDLE};
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/bmp_in_if.sv
// ----------------------------------------------------------------------------
// bmp_in_if
// Input channel of the bit packer: valid/ready plus one input item.
// ----------------------------------------------------------------------------
interface bmp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        buffer_select;
	logic [63:0] value;
	logic [6:0]  bit_count;
	logic [5:0]  read_address;

	modport source (
		output valid, mode, buffer_select, value, bit_count, read_address,
		input  ready
	);

	modport sink (
		input  valid, mode, buffer_select, value, bit_count, read_address,
		output ready
	);
endinterface

FILE: rtl/bmp_out_if.sv
// ----------------------------------------------------------------------------
// bmp_out_if
// Result channel of the bit packer: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface bmp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_word;
	logic [6:0]  word_address;
	logic [4:0]  free_bits;
	logic        overflow;

	modport source (
		output valid, read_word, word_address, free_bits, overflow,
		input  ready
	);

	modport sink (
		input  valid, read_word, word_address, free_bits, overflow,
		output ready
	);
endinterface

FILE: rtl/msb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top
// MSB-first bit packer with a data and a setup buffer, run by a microcoded
// sequencer over a single chunk packer and a 1W/1R word memory.
// Append: one chunk per word touched (up to 5).
// Read: memory read, load of the read word, output.
// Merge: per data word a memory read, a load, one or two chunks and a loop
//   test, then the output step.
// One transaction in flight; the next is taken while a result waits.
// Reset: async, clears both buffers at once through per-word valid bits.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top (
	input  logic      clk,
	input  logic      arst_n,
	bmp_in_if.sink    item,
	bmp_out_if.source result
);
	import bmp_pkg::*;

	ctrl_t             ctrl;
	status_t           status;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_raddr;
	logic [15:0]       mem_rdata;

	bmp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	bmp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.item      (item),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bmp_word_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

endmodule

FILE: rtl/bmp_word_store.sv
// ----------------------------------------------------------------------------
// bmp_word_store
// Word memory for both buffers, one write and one registered read per cycle.
// Per-entry valid bits make never-written words read as zero after reset.
// ----------------------------------------------------------------------------
module bmp_word_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [bmp_pkg::MEM_AW-1:0] waddr,
	input  logic [15:0]               wdata,
	input  logic                      re,
	input  logic [bmp_pkg::MEM_AW-1:0] raddr,
	output logic [15:0]               rdata
);
	import bmp_pkg::*;

	logic [15:0]          mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [15:0]          rdata_q;
	logic                 rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : 16'h0000;

endmodule

FILE: rtl/bmp_sequencer.sv
// ----------------------------------------------------------------------------
// bmp_sequencer
// Step counter over the control store, with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module bmp_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  bmp_pkg::status_t status,
	output bmp_pkg::ctrl_t   ctrl
);
	import bmp_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] pc_inc;

	assign ctrl   = ucode(pc_q);
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		pc_d = pc_inc;
		case (ctrl.jmp)
			J_NEXT:     pc_d = pc_inc;
			J_GOTO:     pc_d = ctrl.target;
			J_DISPATCH: begin
				if (!status.accept) begin
					pc_d = pc_q;
				end else begin
					case (status.mode)
						MODE_APPEND: pc_d = PC_APPEND;
						MODE_MERGE:  pc_d = PC_MERGE;
						MODE_READ:   pc_d = PC_READ;
						default:     pc_d = PC_OUT;
					endcase
				end
			end
			J_IF_REM:   pc_d = status.rem_more  ? ctrl.target : pc_inc;
			J_IF_WORD:  pc_d = status.word_more ? ctrl.target : pc_inc;
			J_WAIT_OUT: pc_d = status.out_busy  ? pc_q : ctrl.target;
			default:    pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

FILE: rtl/bmp_datapath.sv
// ----------------------------------------------------------------------------
// bmp_datapath
// Buffer state, chunk packer and output register, driven by the control word.
// ----------------------------------------------------------------------------
module bmp_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmp_pkg::ctrl_t             ctrl,
	output bmp_pkg::status_t           status,
	bmp_in_if.sink                     item,
	bmp_out_if.source                  result,
	output logic                       mem_we,
	output logic [bmp_pkg::MEM_AW-1:0] mem_waddr,
	output logic [15:0]                mem_wdata,
	output logic                       mem_re,
	output logic [bmp_pkg::MEM_AW-1:0] mem_raddr,
	input  logic [15:0]                mem_rdata
);
	import bmp_pkg::*;

	// per-buffer write pointer, free position and mirror of the partial word
	logic [ADDR_W-1:0] waddr_q [2];
	logic [POS_W-1:0]  pos_q   [2];
	logic [15:0]       cur_q   [2];

	logic              b_q;
	logic [VAL_W-1:0]  val_q;      // remaining bits, left aligned
	logic [CNT_W-1:0]  rem_q;
	logic [RADDR_W-1:0] raddr_q;
	logic [ADDR_W-1:0] idx_q;      // merge read index
	logic              ovf_q;
	logic [15:0]       rword_q;

	logic              out_vld_q;
	logic [15:0]       out_word_q;
	logic [6:0]        out_addr_q;
	logic [4:0]        out_free_q;
	logic              out_ovf_q;

	logic              accept;
	logic              out_busy;
	logic              emit_fire;
	logic [CNT_W-1:0]  cnt_sat;

	logic [ADDR_W-1:0] addr;
	logic [POS_W-1:0]  pos;
	logic              full;
	logic              active;
	logic [POS_W-1:0]  n;
	logic [15:0]       placed;
	logic [15:0]       keep_mask;
	logic [15:0]       word_new;
	logic [CNT_W-1:0]  rem_next;
	logic [ADDR_W-1:0] last;
	logic              raddr_ok;

	assign accept    = item.valid && ctrl.in_ready;
	assign item.ready = ctrl.in_ready;
	assign out_busy  = out_vld_q && !result.ready;
	assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

	assign cnt_sat = (item.bit_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : item.bit_count;

	// chunk: take min(rem, pos) leading bits and place them below the free position
	always_comb begin
		addr      = waddr_q[b_q];
		pos       = pos_q[b_q];
		full      = addr >= ADDR_W'(WORDS_PER_BUFFER);
		active    = (ctrl.op == OP_CHUNK) && (rem_q != '0);
		n         = (rem_q < CNT_W'(pos)) ? rem_q[POS_W-1:0] : pos;
		placed    = val_q[VAL_W-1 -: 16] >> (POS_FULL - pos);
		keep_mask = 16'hFFFF << (pos - n);
		word_new  = cur_q[b_q] | (placed & keep_mask);
		rem_next  = rem_q - CNT_W'(n);
	end

	assign last     = (waddr_q[BUF_DATA] >= ADDR_W'(WORDS_PER_BUFFER))
		? ADDR_W'(WORDS_PER_BUFFER - 1) : waddr_q[BUF_DATA];
	assign raddr_ok = 32'(raddr_q) < 32'(WORDS_PER_BUFFER);

	assign mem_we    = active && !full;
	assign mem_waddr = {b_q, addr[IDX_W-1:0]};
	assign mem_wdata = word_new;
	assign mem_re    = (ctrl.op == OP_RD_SEL) || (ctrl.op == OP_RD_DATA);
	assign mem_raddr = (ctrl.op == OP_RD_SEL) ? {b_q, IDX_W'(raddr_q)}
		: {BUF_DATA, idx_q[IDX_W-1:0]};

	assign status.accept    = accept;
	assign status.mode      = item.mode;
	assign status.rem_more  = active && !full && (rem_next != '0);
	assign status.word_more = idx_q <= last;
	assign status.out_busy  = out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				waddr_q[k] <= '0;
				pos_q[k]   <= POS_FULL;
				cur_q[k]   <= '0;
			end
			rem_q <= '0;
			idx_q <= '0;
			b_q   <= BUF_DATA;
			ovf_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_LOAD: begin
					if (accept) begin
						b_q   <= (item.mode == MODE_MERGE) ? BUF_SETUP : item.buffer_select;
						rem_q <= (item.mode == MODE_APPEND) ? cnt_sat : '0;
						idx_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				OP_CHUNK: begin
					if (active) begin
						if (full) begin
							ovf_q <= 1'b1;
							rem_q <= '0;
						end else begin
							rem_q <= rem_next;
							if (n == pos) begin
								pos_q[b_q]   <= POS_FULL;
								waddr_q[b_q] <= addr + ADDR_W'(1);
								cur_q[b_q]   <= '0;
							end else begin
								pos_q[b_q] <= pos - n;
								cur_q[b_q] <= word_new;
							end
						end
					end
				end
				OP_RD_DATA: idx_q <= idx_q + ADDR_W'(1);
				OP_LD_WORD: rem_q <= CNT_W'(WORD_BITS);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (accept) begin
					val_q   <= item.value << (CNT_W'(MAX_COUNT) - cnt_sat);
					raddr_q <= item.read_address;
					rword_q <= '0;
				end
			end
			OP_CHUNK: begin
				if (active && !full) begin
					val_q <= val_q << n;
				end
			end
			OP_LD_WORD:  val_q   <= {mem_rdata, {(VAL_W-16){1'b0}}};
			OP_LD_RWORD: rword_q <= raddr_ok ? mem_rdata : 16'h0000;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_word_q <= rword_q;
			out_addr_q <= OUT_ADDR_W'(waddr_q[b_q]);
			out_free_q <= pos_q[b_q];
			out_ovf_q  <= ovf_q;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.read_word    = out_word_q;
	assign result.word_address = out_addr_q;
	assign result.free_bits    = out_free_q;
	assign result.overflow     = out_ovf_q;

endmodule

FILE: bench/msb_first_bit_packer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top_test
// Drives append, merge, read and unused-mode transactions into the bit packer
// and checks every result against a predictor of both word buffers. Directed
// corner cases come first. Random traffic follows in four phases of sender
// idling and receiver stalling.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_top_test;
	import bmp_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         PHASE_ITEMS = 488;

	typedef struct {
		logic [1:0]  mode;
		logic        buffer_select;
		logic [63:0] value;
		logic [6:0]  bit_count;
		logic [5:0]  read_address;
		int unsigned idle_pct;
		int unsigned stall_pct;
	} packer_item_t;

	typedef struct packed {
		logic [15:0] read_word;
		logic [6:0]  word_address;
		logic [4:0]  free_bits;
		logic        overflow;
	} packer_result_t;

	logic clk;
	logic arst_n;

	bmp_in_if  in_ch ();
	bmp_out_if out_ch ();

	msb_first_bit_packer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	// predicted buffer contents
	logic [15:0] buf_words [2][WORDS_PER_BUFFER];
	int unsigned buf_addr [2];
	int unsigned buf_pos [2];

	packer_item_t   pending_items [$];
	packer_result_t expected_results [$];
	int unsigned    stall_pct;
	int unsigned    fail_count;

	int unsigned sender_idle [4]   = '{0, 83, 0, 38};
	int unsigned receiver_stall [4] = '{0, 0, 83, 38};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// append the low count bits of v to buffer b, MSB first; 1 if any bit dropped
	function automatic bit pack_bits(input bit b, input logic [63:0] v, input int unsigned count);
		bit dropped = 1'b0;
		int unsigned p;
		if (count > MAX_COUNT)
			count = MAX_COUNT;
		for (int i = count; i > 0; i--) begin
			if (buf_addr[b] >= WORDS_PER_BUFFER) begin
				dropped = 1'b1;
			end else begin
				p = buf_pos[b];
				if (v[i-1])
					buf_words[b][buf_addr[b]][p-1] = 1'b1;
				if (p == 1) begin
					buf_pos[b] = WORD_BITS;
					buf_addr[b]++;
				end else begin
					buf_pos[b] = p - 1;
				end
			end
		end
		return dropped;
	endfunction

	function automatic packer_result_t predict_packer(input logic [1:0] mode, input logic sel,
			input logic [63:0] value, input logic [6:0] count, input logic [5:0] raddr);
		packer_result_t r;
		int unsigned last;
		bit affected;
		r = '0;
		affected = sel;
		case (mode)
			MODE_APPEND: begin
				r.overflow = pack_bits(sel, value, count);
			end
			MODE_MERGE: begin
				last = buf_addr[BUF_DATA];
				if (last >= WORDS_PER_BUFFER)
					last = WORDS_PER_BUFFER - 1;
				for (int i = 0; i <= last; i++)
					if (pack_bits(BUF_SETUP, buf_words[BUF_DATA][i], WORD_BITS))
						r.overflow = 1'b1;
				affected = BUF_SETUP;
			end
			MODE_READ: begin
				if (raddr < WORDS_PER_BUFFER)
					r.read_word = buf_words[sel][raddr];
			end
			default: ;
		endcase
		r.word_address = OUT_ADDR_W'(buf_addr[affected]);
		r.free_bits    = POS_W'(buf_pos[affected]);
		return r;
	endfunction

	function automatic void queue_item(input logic [1:0] mode, input logic sel,
			input logic [63:0] value, input logic [6:0] count, input logic [5:0] raddr,
			input int unsigned idle, input int unsigned stall);
		packer_item_t t;
		t = '{mode, sel, value, count, raddr, idle, stall};
		pending_items.push_back(t);
	endfunction

	function automatic void flag_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// driver: predicts each accepted transaction, then offers the next one
	always @(posedge clk or negedge arst_n) begin : drive
		packer_item_t nxt;
		if (!arst_n) begin
			in_ch.valid         <= 1'b0;
			in_ch.mode          <= '0;
			in_ch.buffer_select <= 1'b0;
			in_ch.value         <= '0;
			in_ch.bit_count     <= '0;
			in_ch.read_address  <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(predict_packer(in_ch.mode, in_ch.buffer_select,
					in_ch.value, in_ch.bit_count, in_ch.read_address));
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() != 0 &&
						$urandom_range(99) >= pending_items[0].idle_pct) begin
					nxt = pending_items.pop_front();
					in_ch.valid         <= 1'b1;
					in_ch.mode          <= nxt.mode;
					in_ch.buffer_select <= nxt.buffer_select;
					in_ch.value         <= nxt.value;
					in_ch.bit_count     <= nxt.bit_count;
					in_ch.read_address  <= nxt.read_address;
					stall_pct           <= nxt.stall_pct;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks results in order, stalls at random
	always @(posedge clk or negedge arst_n) begin : watch
		packer_result_t got;
		packer_result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.read_word, out_ch.word_address, out_ch.free_bits,
					out_ch.overflow};
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected transaction: word %h addr %0d free %0d ovf %b",
						got.read_word, got.word_address, got.free_bits, got.overflow));
				end else begin
					want = expected_results.pop_front();
					if (got !== want)
						flag_mismatch($sformatf(
							"mismatch: word %h/%h addr %0d/%0d free %0d/%0d ovf %b/%b (exp/act)",
							want.read_word, got.read_word, want.word_address, got.word_address,
							want.free_bits, got.free_bits, want.overflow, got.overflow));
				end
			end
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#40_000_000;
		$display("msb_first_bit_packer_top_test failed");
		$finish;
	end

	initial begin
		int unsigned pick;
		logic [1:0]  mode;
		logic [6:0]  count;
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.mode          = '0;
		in_ch.buffer_select = 1'b0;
		in_ch.value         = '0;
		in_ch.bit_count     = '0;
		in_ch.read_address  = '0;
		out_ch.ready        = 1'b0;
		stall_pct           = 0;
		fail_count          = 0;
		for (int b = 0; b < 2; b++) begin
			buf_addr[b] = 0;
			buf_pos[b]  = WORD_BITS;
			for (int w = 0; w < WORDS_PER_BUFFER; w++)
				buf_words[b][w] = '0;
		end

		// directed corners
		queue_item(MODE_READ,   BUF_DATA,  '0, 0, 0, 0, 0);
		queue_item(MODE_READ,   BUF_SETUP, '1, 64, 63, 0, 0);
		queue_item(MODE_UNUSED, BUF_DATA,  '1, 64, 5, 0, 0);
		queue_item(MODE_UNUSED, BUF_SETUP, '0, 3, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_DATA,  '1, 0, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_DATA,  '1, 64, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_DATA,  64'h1, 1, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_DATA,  '0, 15, 0, 0, 0);
		// count above 64 saturates
		queue_item(MODE_APPEND, BUF_DATA,  64'h8000_0000_0000_0001, 127, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_DATA,  64'h55, 7, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_SETUP, 64'h5, 3, 0, 0, 0);
		queue_item(MODE_MERGE,  BUF_DATA,  '0, 0, 0, 0, 0);
		queue_item(MODE_READ,   BUF_SETUP, '0, 0, 0, 0, 0);
		queue_item(MODE_READ,   BUF_SETUP, '0, 0, 1, 0, 0);
		queue_item(MODE_READ,   BUF_DATA,  '0, 0, 4, 0, 0);
		queue_item(MODE_READ,   BUF_DATA,  '0, 0, 6, 0, 0);
		queue_item(MODE_APPEND, BUF_SETUP, '0, 64, 0, 0, 0);
		queue_item(MODE_APPEND, BUF_DATA,  {$urandom, $urandom}, 100, 0, 0, 0);
		queue_item(MODE_MERGE,  BUF_SETUP, '1, 127, 63, 0, 0);
		queue_item(MODE_READ,   BUF_DATA,  '0, 0, 63, 0, 0);
		queue_item(MODE_READ,   BUF_SETUP, '0, 0, 20, 0, 0);

		// random traffic, mostly short appends so the buffers fill gradually
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 56)
					mode = MODE_APPEND;
				else if (pick < 90)
					mode = MODE_READ;
				else if (pick < 93)
					mode = MODE_MERGE;
				else
					mode = MODE_UNUSED;
				pick = $urandom_range(99);
				if (pick < 80)
					count = 7'($urandom_range(4));
				else if (pick < 96)
					count = 7'($urandom_range(64, 5));
				else
					count = 7'($urandom_range(127, 65));
				queue_item(mode, 1'($urandom_range(1)), {$urandom, $urandom}, count,
					6'($urandom_range(63)), sender_idle[ph], receiver_stall[ph]);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("msb_first_bit_packer_top_test passed");
		else
			$display("msb_first_bit_packer_top_test failed");
		$finish;
	end

endmodule
